FILE: rtl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg: shared types and constants of the polymorphic inline cache
// Widths, command codes and the item record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package pic_pkg;
	localparam int SITES = 256;
	localparam int WAYS = 4;
	localparam int SITE_W = 8;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FILL_W = $clog2(WAYS + 1);
	localparam int IDX_W = $clog2(SITES * WAYS);
	localparam int QDEPTH = 2;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic              in_range;
		logic [SITE_W-1:0] site;
		logic [63:0]       tag;
		logic [31:0]       name;
		logic [31:0]       method;
		logic              mod;
		logic              slf;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_DONE,
		ST_CLEAR
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/pic_front.sv
// ----------------------------------------------------------------------------
// pic_front: command intake
// Classifies each item, then holds it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module pic_front
	import pic_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  site,
	input  wire logic signed [63:0] recv_tag,
	input  wire logic [31:0] name_id,
	input  wire logic [31:0] method_handle,
	input  wire logic        module_flag,
	input  wire logic        self_flag,
	output logic             busy,
	output logic             q_valid,
	output item_t            q_item,
	input  wire logic        q_pop
);
	item_t q_mem_q [QDEPTH];
	logic q_wr_q, q_rd_q;
	logic [1:0] q_cnt_q;
	item_t in_item;
	logic push;

	// classify the incoming item
	always_comb begin
		in_item.cmd = cmd_t'(cmd);
		in_item.in_range = ({24'd0, site} < 32'(SITES));
		in_item.site = site;
		in_item.tag = recv_tag;
		in_item.name = name_id;
		in_item.method = method_handle;
		in_item.mod = module_flag;
		in_item.slf = self_flag;
	end

	assign busy = (q_cnt_q == 2'(QDEPTH));
	assign push = start && !busy;
	assign q_valid = (q_cnt_q != 2'd0);
	assign q_item = q_mem_q[q_rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) q_mem_q[q_wr_q] <= in_item;
	end

	// advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q <= 1'b0;
			q_rd_q <= 1'b0;
			q_cnt_q <= 2'd0;
		end else begin
			if (push) q_wr_q <= ~q_wr_q;
			if (q_pop) q_rd_q <= ~q_rd_q;
			q_cnt_q <= q_cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/pic_back.sv
// ----------------------------------------------------------------------------
// pic_back: cache engine
// Reads a site's ways one per cycle, then hits, rewrites, fills or replaces; clear resets fill marks and totals.
// ----------------------------------------------------------------------------
`default_nettype none
module pic_back
	import pic_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire item_t       q_item,
	output logic             q_pop,
	output logic             done,
	output logic             hit,
	output logic [31:0]      found_method,
	output logic             found_module,
	output logic             found_self,
	output logic [31:0]      hit_total,
	output logic [31:0]      miss_total
);
	typedef struct packed {
		logic [63:0] tag;
		logic [31:0] name;
		logic [31:0] method;
		logic        mod;
		logic        slf;
	} way_t;

	way_t way_mem [SITES*WAYS];
	logic [31:0] uses_mem [SITES*WAYS];
	logic [FILL_W-1:0] filled_q [SITES];
	logic [SITES-1:0] fvalid_q;

	state_t state_q, state_d;
	item_t it_q;
	logic [WAY_W:0] way_q;
	logic rd_pend_q;
	way_t rd_way_q;
	logic [31:0] rd_uses_q;
	logic [WAY_W-1:0] rd_idx_q;
	logic found_q;
	logic [WAY_W-1:0] found_idx_q;
	logic [WAY_W-1:0] best_q;
	logic [31:0] best_uses_q;
	logic [FILL_W-1:0] fill_rd_q;
	logic fv_q;
	logic [31:0] hits_q, misses_q;

	logic [FILL_W-1:0] n_cur;
	logic rd_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic match_key;
	logic hit_now;
	logic fin;

	function automatic logic [IDX_W-1:0] idx_of(logic [SITE_W-1:0] s, logic [WAY_W-1:0] w);
		return IDX_W'(s) * IDX_W'(WAYS) + IDX_W'(w);
	endfunction

	assign n_cur = fv_q ? fill_rd_q : '0;
	assign match_key = (rd_way_q.tag == it_q.tag) && (rd_way_q.name == it_q.name);
	// a lookup needs a nonzero method, an update only the key
	assign hit_now = match_key && (it_q.cmd == CMD_UPDATE || rd_way_q.method != 32'd0);
	// stop reading once a match is seen so the matching way stays in the read register
	assign rd_en = (state_q == ST_SCAN) && !found_q && !(rd_pend_q && hit_now) &&
		((WAY_W+1)'(way_q) < (WAY_W+1)'(n_cur));
	assign rd_addr = idx_of(it_q.site, way_q[WAY_W-1:0]);
	// scan finished when all ways are read and no read pending
	assign fin = !rd_en && !rd_pend_q;

	// next state
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: if (q_valid) begin
				q_pop = 1'b1;
				priority if (q_item.cmd == CMD_CLEAR) state_d = ST_CLEAR;
				else if ((q_item.cmd == CMD_LOOKUP && q_item.in_range) ||
					(q_item.cmd == CMD_UPDATE && q_item.in_range &&
					q_item.method != 32'd0)) state_d = ST_SCAN;
				else state_d = ST_DONE;
			end
			ST_SCAN: if (fin || found_q) state_d = ST_WAIT;
			ST_WAIT: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			ST_CLEAR: state_d = ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// registered way reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_way_q <= way_mem[rd_addr];
			rd_uses_q <= uses_mem[rd_addr];
			rd_idx_q <= way_q[WAY_W-1:0];
		end
	end

	// pick the write address for an update
	always_comb begin
		priority if (found_q) wr_addr = idx_of(it_q.site, found_idx_q);
		else if (n_cur < FILL_W'(WAYS)) wr_addr = idx_of(it_q.site, WAY_W'(n_cur));
		else wr_addr = idx_of(it_q.site, best_q);
	end

	// table writes
	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && it_q.cmd == CMD_UPDATE) begin
			way_mem[wr_addr] <= '{tag: it_q.tag, name: it_q.name, method: it_q.method,
				mod: it_q.mod, slf: it_q.slf};
			if (!found_q) uses_mem[wr_addr] <= 32'd0;
		end else if (state_q == ST_WAIT && it_q.cmd == CMD_LOOKUP && found_q) begin
			uses_mem[idx_of(it_q.site, found_idx_q)] <=
				(rd_uses_q == MAX32) ? rd_uses_q : rd_uses_q + 32'd1;
		end
	end

	// fill counts: read when the item is taken, write after the scan
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) fill_rd_q <= filled_q[q_item.site];
		if (state_q == ST_WAIT && it_q.cmd == CMD_UPDATE && !found_q &&
			n_cur < FILL_W'(WAYS)) filled_q[it_q.site] <= n_cur + FILL_W'(1);
	end

	// scan control, totals and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q <= '0;
			hits_q <= '0;
			misses_q <= '0;
			rd_pend_q <= 1'b0;
			found_q <= 1'b0;
			fv_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			rd_pend_q <= rd_en;
			unique case (state_q)
				ST_IDLE: if (q_valid) begin
					it_q <= q_item;
					fv_q <= fvalid_q[q_item.site];
					way_q <= '0;
					found_q <= 1'b0;
					best_q <= '0;
					best_uses_q <= MAX32;
				end
				ST_SCAN: begin
					if (rd_en && !found_q) way_q <= way_q + (WAY_W+1)'(1);
					if (rd_pend_q && !found_q) begin
						if (it_q.cmd == CMD_LOOKUP) begin
							if (match_key && rd_way_q.method != 32'd0) begin
								found_q <= 1'b1;
								found_idx_q <= rd_idx_q;
							end
						end else begin
							if (match_key) begin
								found_q <= 1'b1;
								found_idx_q <= rd_idx_q;
							end
							if (rd_idx_q == '0 || rd_uses_q < best_uses_q) begin
								best_q <= rd_idx_q;
								best_uses_q <= rd_uses_q;
							end
						end
					end
				end
				ST_WAIT: begin
					hit <= 1'b0;
					found_method <= '0;
					found_module <= 1'b0;
					found_self <= 1'b0;
					if (it_q.cmd == CMD_LOOKUP) begin
						if (found_q) begin
							hit <= 1'b1;
							found_method <= rd_way_q.method;
							found_module <= rd_way_q.mod;
							found_self <= rd_way_q.slf;
							if (hits_q != MAX32) hits_q <= hits_q + 32'd1;
						end else if (misses_q != MAX32) misses_q <= misses_q + 32'd1;
					end else if (!found_q && n_cur < FILL_W'(WAYS))
						fvalid_q[it_q.site] <= 1'b1;
				end
				ST_CLEAR: begin
					fvalid_q <= '0;
					hits_q <= '0;
					misses_q <= '0;
				end
				ST_DONE: begin
					if (it_q.cmd != CMD_LOOKUP || !it_q.in_range) begin
						hit <= 1'b0;
						found_method <= '0;
						found_module <= 1'b0;
						found_self <= 1'b0;
					end
					if (it_q.cmd == CMD_LOOKUP && !it_q.in_range) hit <= 1'b0;
					done <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// on a found lookup the read data stays held after scan stops
	assign hit_total = hits_q;
	assign miss_total = misses_q;
endmodule
`default_nettype wire

FILE: rtl/polymorphic_inline_cache_lfu_top.sv
// Sequence: no-op items pass from ST_IDLE to ST_DONE, clear goes through ST_CLEAR, and lookups
// and updates go through ST_SCAN, where the ways are read one per cycle, and then ST_WAIT.
// The back end takes a new item only once it is through with the last one; a two-entry queue
// takes items while busy is low.
// The result strobe done is high for one cycle; the receiver cannot stall.
// Reset: arst_n clears queue, fill marks and totals at once; no clearing pass.
// ----------------------------------------------------------------------------
// polymorphic_inline_cache_lfu_top: per-site inline cache with LFU eviction
// Front end queues commands, back end searches and updates the way tables.
// ----------------------------------------------------------------------------
`default_nettype none
module polymorphic_inline_cache_lfu_top
	import pic_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  site,
	input  wire logic signed [63:0] recv_tag,
	input  wire logic [31:0] name_id,
	input  wire logic [31:0] method_handle,
	input  wire logic        module_flag,
	input  wire logic        self_flag,
	output logic             done,
	output logic             hit,
	output logic [31:0]      found_method,
	output logic             found_module,
	output logic             found_self,
	output logic [31:0]      hit_total,
	output logic [31:0]      miss_total
);
	logic q_valid, q_pop;
	item_t q_item;

	pic_front u_front (
		.clk, .arst_n, .start, .cmd, .site, .recv_tag, .name_id, .method_handle,
		.module_flag, .self_flag, .busy, .q_valid, .q_item, .q_pop
	);

	pic_back u_back (
		.clk, .arst_n, .q_valid, .q_item, .q_pop, .done, .hit, .found_method,
		.found_module, .found_self, .hit_total, .miss_total
	);
endmodule
`default_nettype wire
